// ===== rtl/core/tacs_pkg.sv =====
// Package for the tiny accumulator CPU step block.
// Holds opcodes, field widths, the architectural state struct and the result struct.
// No dependencies.
package tacs_pkg;

   localparam int MemDepth  = 16;
   localparam int AddrWidth = 4;
   localparam int DataWidth = 8;
   localparam int StepWidth = 12;

   localparam logic [StepWidth-1:0] STEP_LIMIT_RESET = 12'd3000;

   // command selector carried in tuser
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // opcodes, high nibble of an instruction byte
   localparam logic [3:0] OP_NOP   = 4'h0;
   localparam logic [3:0] OP_LDA   = 4'h1;
   localparam logic [3:0] OP_STA   = 4'h2;
   localparam logic [3:0] OP_LDB   = 4'h3;
   localparam logic [3:0] OP_STB   = 4'h4;
   localparam logic [3:0] OP_ADD   = 4'h5;
   localparam logic [3:0] OP_SUB   = 4'h6;
   localparam logic [3:0] OP_JMP   = 4'h7;
   localparam logic [3:0] OP_JNZ   = 4'h8;
   localparam logic [3:0] OP_JNC   = 4'h9;
   localparam logic [3:0] OP_BAD_A = 4'hA;
   localparam logic [3:0] OP_BAD_B = 4'hB;
   localparam logic [3:0] OP_BAD_C = 4'hC;
   localparam logic [3:0] OP_BAD_D = 4'hD;
   localparam logic [3:0] OP_HLT   = 4'hE;
   localparam logic [3:0] OP_OUT   = 4'hF;

   typedef struct packed {
      logic [AddrWidth-1:0] pc;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      logic                 zero;
      logic                 carry;
      logic                 halt;
      logic [StepWidth-1:0] steps;
   } cpu_state_type;

   typedef struct packed {
      logic                 en;
      logic [AddrWidth-1:0] addr;
      logic [DataWidth-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic                 bad_opcode;
      logic [DataWidth-1:0] out_value;
      logic                 out_valid;
      logic                 halted;
      logic                 carry_flag;
      logic                 zero_flag;
      logic [DataWidth-1:0] register_b;
      logic [DataWidth-1:0] accumulator_a;
      logic [AddrWidth-1:0] program_counter;
   } rsp_type;

endpackage

// ===== rtl/core/tacs_exec.sv =====
// Execute unit of the tiny accumulator CPU: one load or one instruction step.
// Purely combinational: next state, memory write and result item.
// Depends on tacs_pkg.
module tacs_exec (
   input  logic                           cmd,
   input  logic [tacs_pkg::AddrWidth-1:0] load_addr,
   input  logic [tacs_pkg::DataWidth-1:0] load_data,
   input  tacs_pkg::cpu_state_type        state_cur,
   input  logic [tacs_pkg::DataWidth-1:0] mem [tacs_pkg::MemDepth],
   input  logic [tacs_pkg::StepWidth-1:0] step_limit,
   output tacs_pkg::cpu_state_type        state_nxt,
   output tacs_pkg::mem_wr_type           mem_wr,
   output tacs_pkg::rsp_type              result
);

   logic [tacs_pkg::DataWidth-1:0] instr;
   logic [3:0]                     op;
   logic [tacs_pkg::AddrWidth-1:0] arg;
   logic [tacs_pkg::DataWidth-1:0] operand;
   logic [tacs_pkg::DataWidth:0]   sum;
   logic [tacs_pkg::DataWidth:0]   diff;
   logic                           run;
   logic                           out_hit;
   logic                           bad_hit;

   assign instr   = mem[state_cur.pc];
   assign op      = instr[7:4];
   assign arg     = instr[3:0];
   assign operand = mem[arg];
   assign sum     = {1'b0, state_cur.a} + {1'b0, state_cur.b};
   // borrow lands in the top bit
   assign diff    = {1'b0, state_cur.a} - {1'b0, state_cur.b};
   assign run     = (cmd == tacs_pkg::CMD_STEP) && !state_cur.halt
                    && (state_cur.steps < step_limit);

   always_comb begin
      state_nxt = state_cur;
      mem_wr    = '0;
      out_hit   = 1'b0;
      bad_hit   = 1'b0;
      if (cmd == tacs_pkg::CMD_LOAD) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = load_addr;
         mem_wr.data = load_data;
      end else if (run) begin
         state_nxt.pc    = state_cur.pc + 1'b1;
         state_nxt.steps = state_cur.steps + 1'b1;
         unique case (op)
            tacs_pkg::OP_LDA: state_nxt.a = operand;
            tacs_pkg::OP_STA: begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = arg;
               mem_wr.data = state_cur.a;
            end
            tacs_pkg::OP_LDB: state_nxt.b = operand;
            tacs_pkg::OP_STB: begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = arg;
               mem_wr.data = state_cur.b;
            end
            tacs_pkg::OP_ADD: begin
               state_nxt.b     = sum[7:0];
               state_nxt.carry = sum[8];
               state_nxt.zero  = (sum[7:0] == '0);
            end
            tacs_pkg::OP_SUB: begin
               state_nxt.b     = diff[7:0];
               state_nxt.carry = diff[8];
               state_nxt.zero  = (diff[7:0] == '0);
            end
            tacs_pkg::OP_JMP: state_nxt.pc = arg;
            tacs_pkg::OP_JNZ: if (!state_cur.zero) state_nxt.pc = arg;
            tacs_pkg::OP_JNC: if (!state_cur.carry) state_nxt.pc = arg;
            tacs_pkg::OP_BAD_A, tacs_pkg::OP_BAD_B,
            tacs_pkg::OP_BAD_C, tacs_pkg::OP_BAD_D: bad_hit = 1'b1;
            tacs_pkg::OP_HLT: state_nxt.halt = 1'b1;
            tacs_pkg::OP_OUT: out_hit = 1'b1;
            default: ;  // NOP
         endcase
      end
   end

   always_comb begin
      result.program_counter = state_nxt.pc;
      result.accumulator_a   = state_nxt.a;
      result.register_b      = state_nxt.b;
      result.zero_flag       = state_nxt.zero;
      result.carry_flag      = state_nxt.carry;
      result.halted          = state_nxt.halt || (state_nxt.steps >= step_limit);
      result.out_valid       = out_hit;
      result.out_value       = out_hit ? state_cur.a : '0;
      result.bad_opcode      = bad_hit;
   end

endmodule

// ===== rtl/core/tiny_accumulator_cpu_step.sv =====
// Tiny accumulator CPU step block: top level with input, state and result registers.
// Depends on tacs_pkg and tacs_exec.
//
// Usage:
//   req channel: tuser = command (0 load a memory byte, 1 run one instruction),
//     tdata = load_address, load_data. Each item yields exactly one rsp item.
//   rsp channel: tdata = state after the item plus OUT and bad-opcode flags.
//   csr channel: writes step_limit (12 bits); always ready, apply while idle.
// Flow: an accepted item waits in the input register, then is executed into the result
//   register, which offers its rsp item, once that register is empty or being read.
// Throughput: one item per cycle while rsp_tready is high. The 16-byte memory is in
//   flip-flops so fetch, operand read, execute and write-back are all combinational.
// Reset: memory, PC, A, B, flags and step counter clear; step_limit = 3000;
//   both channels empty.
// Stall: with a result offered and rsp_tready low, the result register holds;
//   the input register takes one more item, then req_tready drops till the result moves.
module tiny_accumulator_cpu_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] command
   input  logic [15:0] req_tdata,   // [3:0] load_address, [11:4] load_data, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] program_counter, [11:4] accumulator_a, [19:12] register_b,
   // [20] zero_flag, [21] carry_flag, [22] halted, [23] out_valid,
   // [31:24] out_value, [32] bad_opcode, [39:33] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   logic                           req_valid_ff;
   logic                           req_cmd_ff;
   logic [tacs_pkg::AddrWidth-1:0] req_addr_ff;
   logic [tacs_pkg::DataWidth-1:0] req_data_ff;
   logic                           rsp_valid_ff;
   tacs_pkg::rsp_type              rsp_ff;
   tacs_pkg::cpu_state_type        state_ff;
   tacs_pkg::cpu_state_type        state_in;
   logic [tacs_pkg::DataWidth-1:0] mem_ff [tacs_pkg::MemDepth];
   logic [tacs_pkg::StepWidth-1:0] limit_ff;
   tacs_pkg::mem_wr_type           mem_wr;
   tacs_pkg::rsp_type              rsp_in;
   logic                           advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   tacs_exec u_exec (
      .cmd        (req_cmd_ff),
      .load_addr  (req_addr_ff),
      .load_data  (req_data_ff),
      .state_cur  (state_ff),
      .mem        (mem_ff),
      .step_limit (limit_ff),
      .state_nxt  (state_in),
      .mem_wr     (mem_wr),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_cmd_ff  <= req_tuser;
         req_addr_ff <= req_tdata[3:0];
         req_data_ff <= req_tdata[11:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tacs_pkg::MemDepth; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (advance && mem_wr.en) begin
         mem_ff[mem_wr.addr] <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tacs_pkg::STEP_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.bad_opcode, rsp_ff.out_value, rsp_ff.out_valid,
                        rsp_ff.halted, rsp_ff.carry_flag, rsp_ff.zero_flag,
                        rsp_ff.register_b, rsp_ff.accumulator_a, rsp_ff.program_counter};

endmodule

// ===== tb/sv/tiny_accumulator_cpu_step_tb.sv =====
// Self-checking testbench for the tiny accumulator CPU step block.
// Loads programs over the req stream, single-steps them and checks every rsp item
// against a cycle-free model of the CPU. Depends on tacs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tiny_accumulator_cpu_step_tb;

   localparam int TotalItems = 1230;
   localparam logic [tacs_pkg::StepWidth-1:0] LimitMax = '1;

   // Architectural model of the CPU plus the queue of states it expects to see.
   class cpu_scoreboard_type;
      logic [tacs_pkg::DataWidth-1:0] mem [tacs_pkg::MemDepth];
      logic [tacs_pkg::AddrWidth-1:0] pc;
      logic [tacs_pkg::DataWidth-1:0] a;
      logic [tacs_pkg::DataWidth-1:0] b;
      logic                           zero;
      logic                           carry;
      logic                           halt;
      logic [tacs_pkg::StepWidth-1:0] steps;
      logic [tacs_pkg::StepWidth-1:0] limit;
      tacs_pkg::rsp_type              expected_states[$];
      int errors;
      int items_noted;
      int results_checked;
      int executed;
      int out_count;
      int bad_count;

      function new();
         foreach (mem[i]) mem[i] = '0;
         pc = '0;
         a = '0;
         b = '0;
         zero = 1'b0;
         carry = 1'b0;
         halt = 1'b0;
         steps = '0;
         limit = tacs_pkg::STEP_LIMIT_RESET;
         errors = 0;
         items_noted = 0;
         results_checked = 0;
         executed = 0;
         out_count = 0;
         bad_count = 0;
      endfunction

      function void set_limit(logic [tacs_pkg::StepWidth-1:0] value);
         limit = value;
      endfunction

      function void take_item(logic cmd, logic [tacs_pkg::AddrWidth-1:0] addr,
                              logic [tacs_pkg::DataWidth-1:0] data);
         tacs_pkg::rsp_type              r;
         logic [tacs_pkg::DataWidth-1:0] instr;
         logic [3:0]                     op;
         logic [3:0]                     arg;
         logic [tacs_pkg::DataWidth:0]   sum;
         r = '0;
         items_noted++;
         if (cmd == tacs_pkg::CMD_LOAD) begin
            mem[addr] = data;
         end else if (!halt && steps < limit) begin
            instr = mem[pc];
            op = instr[7:4];
            arg = instr[3:0];
            pc = pc + 1'b1;
            case (op)
               tacs_pkg::OP_LDA: a = mem[arg];
               tacs_pkg::OP_STA: mem[arg] = a;
               tacs_pkg::OP_LDB: b = mem[arg];
               tacs_pkg::OP_STB: mem[arg] = b;
               tacs_pkg::OP_ADD, tacs_pkg::OP_SUB: begin
                  // ninth bit is the carry on add and the borrow on subtract
                  sum = (op == tacs_pkg::OP_ADD) ? {1'b0, a} + {1'b0, b}
                                                 : {1'b0, a} - {1'b0, b};
                  carry = sum[tacs_pkg::DataWidth];
                  b = sum[tacs_pkg::DataWidth-1:0];
                  zero = (b == '0);
               end
               tacs_pkg::OP_JMP: pc = arg;
               tacs_pkg::OP_JNZ: if (!zero) pc = arg;
               tacs_pkg::OP_JNC: if (!carry) pc = arg;
               tacs_pkg::OP_BAD_A, tacs_pkg::OP_BAD_B,
               tacs_pkg::OP_BAD_C, tacs_pkg::OP_BAD_D: begin
                  r.bad_opcode = 1'b1;
                  bad_count++;
               end
               tacs_pkg::OP_HLT: halt = 1'b1;
               tacs_pkg::OP_OUT: begin
                  r.out_valid = 1'b1;
                  r.out_value = a;
                  out_count++;
               end
               default: ;
            endcase
            steps = steps + 1'b1;
            executed++;
         end
         r.program_counter = pc;
         r.accumulator_a = a;
         r.register_b = b;
         r.zero_flag = zero;
         r.carry_flag = carry;
         r.halted = halt || (steps >= limit);
         expected_states.push_back(r);
      endfunction

      task report(string field, logic [15:0] got, logic [15:0] want);
         $display("MISMATCH %s: got %0h expected %0h (result %0d)",
                  field, got, want, results_checked);
         errors++;
      endtask

      task check_result(logic [39:0] tdata);
         tacs_pkg::rsp_type got;
         tacs_pkg::rsp_type want;
         results_checked++;
         if (expected_states.size() == 0) begin
            report("result with nothing expected", tdata[15:0], '0);
         end else begin
            got = tacs_pkg::rsp_type'(tdata[32:0]);
            want = expected_states.pop_front();
            if (got.program_counter !== want.program_counter)
               report("program_counter", 16'(got.program_counter),
                      16'(want.program_counter));
            if (got.accumulator_a !== want.accumulator_a)
               report("accumulator_a", 16'(got.accumulator_a), 16'(want.accumulator_a));
            if (got.register_b !== want.register_b)
               report("register_b", 16'(got.register_b), 16'(want.register_b));
            if (got.zero_flag !== want.zero_flag)
               report("zero_flag", 16'(got.zero_flag), 16'(want.zero_flag));
            if (got.carry_flag !== want.carry_flag)
               report("carry_flag", 16'(got.carry_flag), 16'(want.carry_flag));
            if (got.halted !== want.halted)
               report("halted", 16'(got.halted), 16'(want.halted));
            if (got.out_valid !== want.out_valid)
               report("out_valid", 16'(got.out_valid), 16'(want.out_valid));
            if (got.out_value !== want.out_value)
               report("out_value", 16'(got.out_value), 16'(want.out_value));
            if (got.bad_opcode !== want.bad_opcode)
               report("bad_opcode", 16'(got.bad_opcode), 16'(want.bad_opcode));
            if (tdata[39:33] !== '0)
               report("tdata padding", 16'(tdata[39:33]), '0);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [11:0] csr_data;

   int send_idle_pct;
   int rsp_stall_pct;
   int hold_request;
   int hold_left;

   cpu_scoreboard_type cpu = new();

   tiny_accumulator_cpu_step i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Receiver: random back-pressure, or a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         cpu.check_result(rsp_tdata);
   end

   // Called just after a falling edge; returns just after a falling edge once the item is accepted.
   task automatic send_item(input logic cmd, input logic [tacs_pkg::AddrWidth-1:0] addr,
                            input logic [tacs_pkg::DataWidth-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, data, addr};
      do @(posedge clock); while (!req_tready);
      cpu.take_item(cmd, addr, data);
      @(negedge clock);
   endtask

   function automatic logic [tacs_pkg::DataWidth-1:0] random_instr();
      logic [3:0] op;
      op = 4'($urandom_range(15));
      if (op == tacs_pkg::OP_HLT)
         op = tacs_pkg::OP_OUT;
      else if (op >= tacs_pkg::OP_BAD_A && op <= tacs_pkg::OP_BAD_D
               && $urandom_range(2) != 0)
         op = tacs_pkg::OP_LDA;
      return {op, 4'($urandom_range(15))};
   endfunction

   // HLT is final, so a pending one gets overwritten before stepping onto it.
   task automatic step_cpu();
      if (cpu.mem[cpu.pc][7:4] == tacs_pkg::OP_HLT)
         send_item(tacs_pkg::CMD_LOAD, cpu.pc, random_instr());
      send_item(tacs_pkg::CMD_STEP, 4'($urandom_range(15)), 8'($urandom_range(255)));
   endtask

   task automatic run_program_episode();
      logic [tacs_pkg::AddrWidth-1:0] start;
      int n_loads;
      int n_steps;
      start = ($urandom_range(1) == 0) ? cpu.pc : 4'($urandom_range(15));
      n_loads = $urandom_range(1, tacs_pkg::MemDepth);
      n_steps = $urandom_range(4, 24);
      for (int k = 0; k < n_loads; k++)
         send_item(tacs_pkg::CMD_LOAD, start + 4'(k),
                   ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : random_instr());
      for (int k = 0; k < n_steps; k++) begin
         if ($urandom_range(99) < 8)
            send_item(tacs_pkg::CMD_LOAD, 4'($urandom_range(15)),
                      8'($urandom_range(255)));
         step_cpu();
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) begin
         if ($urandom_range(1) == 0)
            step_cpu();
         else
            send_item(tacs_pkg::CMD_LOAD, 4'($urandom_range(15)),
                      8'($urandom_range(255)));
      end
   endtask

   task automatic write_limit(input logic [tacs_pkg::StepWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      cpu.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops offering items and waits until the block has drained.
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (cpu.expected_states.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int stage;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = tacs_pkg::CMD_LOAD;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_request = 0;
      hold_left = 0;
      send_idle_pct = 15;
      rsp_stall_pct = 65;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // cleared memory executes as NOP, so the program starts at address 1
      step_cpu();
      send_item(tacs_pkg::CMD_LOAD, 4'd0,  8'h00);
      send_item(tacs_pkg::CMD_LOAD, 4'd1,  {tacs_pkg::OP_LDA, 4'd14});
      send_item(tacs_pkg::CMD_LOAD, 4'd2,  {tacs_pkg::OP_LDB, 4'd15});
      send_item(tacs_pkg::CMD_LOAD, 4'd3,  {tacs_pkg::OP_ADD, 4'd0});   // FF + 01: zero, carry
      send_item(tacs_pkg::CMD_LOAD, 4'd4,  {tacs_pkg::OP_OUT, 4'd0});
      send_item(tacs_pkg::CMD_LOAD, 4'd5,  {tacs_pkg::OP_JNZ, 4'd2});   // not taken
      send_item(tacs_pkg::CMD_LOAD, 4'd6,  {tacs_pkg::OP_JNC, 4'd8});   // not taken
      send_item(tacs_pkg::CMD_LOAD, 4'd7,  {tacs_pkg::OP_SUB, 4'd0});
      send_item(tacs_pkg::CMD_LOAD, 4'd8,  {tacs_pkg::OP_STB, 4'd13});  // 13 becomes OUT
      send_item(tacs_pkg::CMD_LOAD, 4'd9,  {tacs_pkg::OP_BAD_A, 4'd11});
      send_item(tacs_pkg::CMD_LOAD, 4'd10, {tacs_pkg::OP_JNC, 4'd12});  // taken
      send_item(tacs_pkg::CMD_LOAD, 4'd12, {tacs_pkg::OP_JMP, 4'd13});
      send_item(tacs_pkg::CMD_LOAD, 4'd14, 8'hFF);
      send_item(tacs_pkg::CMD_LOAD, 4'd15, 8'h01);
      repeat (14) step_cpu();                        // runs through 15 and wraps to 0

      // a limit at or below the step count stops execution at once
      wait_all_results();
      write_limit('0);
      step_cpu();
      send_item(tacs_pkg::CMD_LOAD, 4'd11, {tacs_pkg::OP_BAD_D, 4'd0});
      step_cpu();
      wait_all_results();
      write_limit(cpu.steps + 12'd3);
      repeat (6) step_cpu();
      wait_all_results();
      write_limit(LimitMax);

      stage = 0;
      while (cpu.items_noted < TotalItems) begin
         if (stage == 0 && cpu.items_noted >= 300) begin
            hold_request = 150;
            stage = 1;
         end else if (stage == 1 && cpu.items_noted >= 420) begin
            send_idle_pct = 65;
            rsp_stall_pct = 15;
            stage = 2;
         end else if (stage == 2 && cpu.items_noted >= 550) begin
            wait_all_results();
            write_limit(cpu.steps + 12'd6);
            stage = 3;
         end else if (stage == 3 && cpu.items_noted >= 680) begin
            wait_all_results();
            write_limit(LimitMax);
            stage = 4;
         end else if (stage == 4 && cpu.items_noted >= 820) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            hold_request = 100;
            stage = 5;
         end
         if ($urandom_range(99) < 75)
            run_program_episode();
         else
            send_noise();
      end

      // halt for good, then load and step while halted
      send_item(tacs_pkg::CMD_LOAD, cpu.pc, {tacs_pkg::OP_HLT, 4'($urandom_range(15))});
      send_item(tacs_pkg::CMD_STEP, 4'($urandom_range(15)), 8'($urandom_range(255)));
      send_item(tacs_pkg::CMD_STEP, 4'($urandom_range(15)), 8'($urandom_range(255)));
      send_item(tacs_pkg::CMD_LOAD, 4'($urandom_range(15)), 8'($urandom_range(255)));
      send_item(tacs_pkg::CMD_STEP, 4'($urandom_range(15)), 8'($urandom_range(255)));

      wait_all_results();
      repeat (10) @(negedge clock);
      if (cpu.expected_states.size() != 0)
         cpu.report("results missing", 16'(cpu.expected_states.size()), '0);
      $display("Sent %0d items, checked %0d results: %0d instructions, %0d OUT, %0d undefined",
               cpu.items_noted, cpu.results_checked, cpu.executed, cpu.out_count,
               cpu.bad_count);
      $display("Step limit taken through reset value, 0, two small caps and 4095; ended halted");
      if (cpu.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
